FILE: sv/alu8_pkg.sv
// Package with operation codes, flag positions and CB-prefix codes for the eight-bit ALU.
`timescale 1ns / 1ps
`default_nettype none
package alu8_pkg;

	// Operation codes carried on req_type.
	typedef enum logic [4:0] {
		OP_ADD   = 5'd0,
		OP_ADC   = 5'd1,
		OP_SUB   = 5'd2,
		OP_SBC   = 5'd3,
		OP_AND   = 5'd4,
		OP_XOR   = 5'd5,
		OP_OR    = 5'd6,
		OP_CP    = 5'd7,
		OP_RLCA  = 5'd8,
		OP_RRCA  = 5'd9,
		OP_RLA   = 5'd10,
		OP_RRA   = 5'd11,
		OP_DAA   = 5'd12,
		OP_CPL   = 5'd13,
		OP_SCF   = 5'd14,
		OP_CCF   = 5'd15,
		OP_CB    = 5'd16,
		OP_ADD16 = 5'd17,
		OP_SP_E8 = 5'd18
	} alu_op_t;

	// Flag bit positions in the packed flag nibble.
	localparam int unsigned FLAG_Z = 3;
	localparam int unsigned FLAG_N = 2;
	localparam int unsigned FLAG_H = 1;
	localparam int unsigned FLAG_C = 0;

	// CB opcode groups, taken from bits 7..6 of the CB opcode.
	localparam logic [1:0] CB_GRP_SHIFT = 2'd0;
	localparam logic [1:0] CB_GRP_BIT   = 2'd1;
	localparam logic [1:0] CB_GRP_RES   = 2'd2;
	localparam logic [1:0] CB_GRP_SET   = 2'd3;

	// Shift group operations, taken from bits 5..3 of the CB opcode.
	localparam logic [2:0] CB_RLC  = 3'd0;
	localparam logic [2:0] CB_RRC  = 3'd1;
	localparam logic [2:0] CB_RL   = 3'd2;
	localparam logic [2:0] CB_RR   = 3'd3;
	localparam logic [2:0] CB_SLA  = 3'd4;
	localparam logic [2:0] CB_SRA  = 3'd5;
	localparam logic [2:0] CB_SWAP = 3'd6;
	localparam logic [2:0] CB_SRL  = 3'd7;

	// Decimal adjust limits and correction nibble.
	localparam logic [3:0] DAA_LO_LIMIT = 4'h9;
	localparam logic [7:0] DAA_LIMIT    = 8'h99;
	localparam logic [3:0] DAA_FIX      = 4'h6;

endpackage
`default_nettype wire

FILE: sv/eight_bit_alu_with_bit_ops.sv
// Top level of the pipelined eight-bit ALU with CB-prefix bit operations.
//
// Usage: an operation enters on the input channel (in_valid / in_ready) with
// req_type, operand_a, operand_b and flags_in. Exactly one transaction leaves on
// the output channel (out_valid / out_ready) for every input transaction, in order,
// carrying result, flags_out and result_write.
// Path: an accepted input transaction passes through the decode, arithmetic and
// output registers in turn before it shows on out_valid. Throughput: one
// transaction per cycle while out_ready stays high, set by three register stages
// (decode, arithmetic and result select, zero detect and flag packing), each of
// which holds one item.
// Stalls: each stage moves forward when the stage after it is empty or moving,
// so bubbles are squeezed out. When out_ready stays low the block keeps taking
// transactions until all three stages hold one; only then does in_ready fall.
// Reset: arst_n clears the stage valid bits at once; the pipeline comes out of
// reset empty and ready. The data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module eight_bit_alu_with_bit_ops (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [4:0]  req_type,
	input  wire logic [15:0] operand_a,
	input  wire logic [15:0] operand_b,
	input  wire logic [3:0]  flags_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      result,
	output logic [3:0]       flags_out,
	output logic             result_write
);
	import alu8_pkg::*;

	// Stage valid bits and the ready chain.
	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	// Stage 1: registered inputs plus decode results.
	alu_op_t     op_s1;
	logic [15:0] a_s1;
	logic [15:0] b_s1;
	logic [3:0]  fl_s1;
	logic        cin_s1;
	logic [7:0]  daa_adj_s1;
	logic        daa_c_s1;
	logic [7:0]  cb_mask_s1;

	// Stage 2: selected result, flags except a pending zero test.
	logic [15:0] res_s2;
	logic [3:0]  nf_s2;
	logic        wr_s2;
	logic        zres_s2;
	logic [7:0]  zsrc_s2;

	// Stage 3: output registers.
	logic [15:0] res_s3;
	logic [3:0]  fl_s3;
	logic        wr_s3;

	// Decode logic feeding stage 1.
	alu_op_t    op_in;
	logic       daa_lo;
	logic       daa_hi;
	logic [7:0] a_in8;

	// Arithmetic logic feeding stage 2.
	logic [15:0] res_c;
	logic [3:0]  nf_c;
	logic        wr_c;
	logic        zres_c;
	logic [7:0]  zsrc_c;

	assign rdy_s3   = !v_s3 || out_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// Decode: carry-in for adc/sbc, the decimal adjust value and the CB bit mask.
	always_comb begin
		op_in  = alu_op_t'(req_type);
		a_in8  = operand_a[7:0];
		daa_lo = flags_in[FLAG_H] || (!flags_in[FLAG_N] && (a_in8[3:0] > DAA_LO_LIMIT));
		daa_hi = flags_in[FLAG_C] || (!flags_in[FLAG_N] && (a_in8 > DAA_LIMIT));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			op_s1      <= op_in;
			a_s1       <= operand_a;
			b_s1       <= operand_b;
			fl_s1      <= flags_in;
			cin_s1     <= ((op_in == OP_ADC) || (op_in == OP_SBC)) && flags_in[FLAG_C];
			daa_adj_s1 <= {(daa_hi ? DAA_FIX : 4'h0), (daa_lo ? DAA_FIX : 4'h0)};
			daa_c_s1   <= daa_hi;
			cb_mask_s1 <= 8'h01 << operand_b[5:3];
		end
	end

	// Arithmetic, logic and shift work, then selection by operation.
	always_comb begin
		logic [7:0]  a8;
		logic [7:0]  b8;
		logic [8:0]  sum9;
		logic [4:0]  half5;
		logic [8:0]  dif9;
		logic [4:0]  hdif5;
		logic [16:0] sum17;
		logic [12:0] half13;
		logic [7:0]  cb_r;
		logic        cb_c;

		a8     = a_s1[7:0];
		b8     = b_s1[7:0];
		sum9   = {1'b0, a8} + {1'b0, b8} + {8'h00, cin_s1};
		half5  = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'h0, cin_s1};
		dif9   = {1'b0, a8} - {1'b0, b8} - {8'h00, cin_s1};
		hdif5  = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'h0, cin_s1};
		sum17  = {1'b0, a_s1} + {1'b0, b_s1};
		half13 = {1'b0, a_s1[11:0]} + {1'b0, b_s1[11:0]};

		case (b8[5:3])
			CB_RLC:  begin cb_c = a8[7]; cb_r = {a8[6:0], a8[7]}; end
			CB_RRC:  begin cb_c = a8[0]; cb_r = {a8[0], a8[7:1]}; end
			CB_RL:   begin cb_c = a8[7]; cb_r = {a8[6:0], fl_s1[FLAG_C]}; end
			CB_RR:   begin cb_c = a8[0]; cb_r = {fl_s1[FLAG_C], a8[7:1]}; end
			CB_SLA:  begin cb_c = a8[7]; cb_r = {a8[6:0], 1'b0}; end
			CB_SRA:  begin cb_c = a8[0]; cb_r = {a8[7], a8[7:1]}; end
			CB_SWAP: begin cb_c = 1'b0;  cb_r = {a8[3:0], a8[7:4]}; end
			default: begin cb_c = a8[0]; cb_r = {1'b0, a8[7:1]}; end
		endcase

		res_c  = 16'h0000;
		nf_c   = fl_s1;
		wr_c   = 1'b1;
		zres_c = 1'b0;
		zsrc_c = 8'h00;

		case (op_s1)
			OP_ADD, OP_ADC: begin
				res_c  = {8'h00, sum9[7:0]};
				nf_c   = {1'b0, 1'b0, half5[4], sum9[8]};
				zres_c = 1'b1;
				zsrc_c = sum9[7:0];
			end
			OP_SUB, OP_SBC: begin
				res_c  = {8'h00, dif9[7:0]};
				nf_c   = {1'b0, 1'b1, hdif5[4], dif9[8]};
				zres_c = 1'b1;
				zsrc_c = dif9[7:0];
			end
			OP_CP: begin
				// Compare sets flags from the difference but keeps the accumulator.
				res_c  = {8'h00, a8};
				nf_c   = {1'b0, 1'b1, hdif5[4], dif9[8]};
				wr_c   = 1'b0;
				zres_c = 1'b1;
				zsrc_c = dif9[7:0];
			end
			OP_AND: begin
				res_c  = {8'h00, a8 & b8};
				nf_c   = 4'b0010;
				zres_c = 1'b1;
				zsrc_c = a8 & b8;
			end
			OP_XOR: begin
				res_c  = {8'h00, a8 ^ b8};
				nf_c   = 4'b0000;
				zres_c = 1'b1;
				zsrc_c = a8 ^ b8;
			end
			OP_OR: begin
				res_c  = {8'h00, a8 | b8};
				nf_c   = 4'b0000;
				zres_c = 1'b1;
				zsrc_c = a8 | b8;
			end
			OP_RLCA: begin
				res_c = {8'h00, a8[6:0], a8[7]};
				nf_c  = {3'b000, a8[7]};
			end
			OP_RRCA: begin
				res_c = {8'h00, a8[0], a8[7:1]};
				nf_c  = {3'b000, a8[0]};
			end
			OP_RLA: begin
				res_c = {8'h00, a8[6:0], fl_s1[FLAG_C]};
				nf_c  = {3'b000, a8[7]};
			end
			OP_RRA: begin
				res_c = {8'h00, fl_s1[FLAG_C], a8[7:1]};
				nf_c  = {3'b000, a8[0]};
			end
			OP_DAA: begin
				if (fl_s1[FLAG_N]) begin
					zsrc_c = a8 - daa_adj_s1;
				end else begin
					zsrc_c = a8 + daa_adj_s1;
				end
				res_c  = {8'h00, zsrc_c};
				nf_c   = {1'b0, fl_s1[FLAG_N], 1'b0, daa_c_s1};
				zres_c = 1'b1;
			end
			OP_CPL: begin
				res_c = {8'h00, ~a8};
				nf_c  = {fl_s1[FLAG_Z], 1'b1, 1'b1, fl_s1[FLAG_C]};
			end
			OP_SCF: begin
				res_c = {8'h00, a8};
				wr_c  = 1'b0;
				nf_c  = {fl_s1[FLAG_Z], 3'b001};
			end
			OP_CCF: begin
				res_c = {8'h00, a8};
				wr_c  = 1'b0;
				nf_c  = {fl_s1[FLAG_Z], 2'b00, ~fl_s1[FLAG_C]};
			end
			OP_CB: begin
				case (b8[7:6])
					CB_GRP_BIT: begin
						res_c = {8'h00, a8};
						wr_c  = 1'b0;
						nf_c  = {~|(a8 & cb_mask_s1), 1'b0, 1'b1, fl_s1[FLAG_C]};
					end
					CB_GRP_RES: begin
						res_c = {8'h00, a8 & ~cb_mask_s1};
					end
					CB_GRP_SET: begin
						res_c = {8'h00, a8 | cb_mask_s1};
					end
					default: begin
						res_c  = {8'h00, cb_r};
						nf_c   = {3'b000, cb_c};
						zres_c = 1'b1;
						zsrc_c = cb_r;
					end
				endcase
			end
			OP_ADD16: begin
				res_c = sum17[15:0];
				nf_c  = {fl_s1[FLAG_Z], 1'b0, half13[12], sum17[16]};
			end
			OP_SP_E8: begin
				// The carries come from the unsigned low byte sum; the result
				// uses the sign-extended byte.
				res_c = a_s1 + {{8{b8[7]}}, b8};
				nf_c  = {2'b00, half5[4], sum9[8]};
			end
			default: begin
				res_c = 16'h0000;
				nf_c  = fl_s1;
				wr_c  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			res_s2  <= res_c;
			nf_s2   <= nf_c;
			wr_s2   <= wr_c;
			zres_s2 <= zres_c;
			zsrc_s2 <= zsrc_c;
		end
	end

	// Stage 3: zero test where the operation takes Z from a byte, then the outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && rdy_s3) begin
			res_s3 <= res_s2;
			fl_s3  <= {(zres_s2 ? (zsrc_s2 == 8'h00) : nf_s2[FLAG_Z]), nf_s2[2:0]};
			wr_s3  <= wr_s2;
		end
	end

	assign out_valid    = v_s3;
	assign result       = res_s3;
	assign flags_out    = fl_s3;
	assign result_write = wr_s3;

`ifndef SYNTHESIS
	// The input side only stalls when every stage holds a transaction.
	a_full_before_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && v_s2 && v_s3))
		else $error("in_ready low while a pipeline stage is empty");

	// An accepted transaction always lands in stage 1.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> v_s1)
		else $error("accepted transaction missing from stage 1");

	// A stage 1 item that cannot move holds its operation.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !rdy_s2) |=> (v_s1 && $stable(op_s1) && $stable(a_s1)))
		else $error("stalled stage 1 item changed");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/eight_bit_alu_with_bit_ops_tb.sv
// Self-checking testbench for the eight-bit ALU with CB-prefix bit operations.
`timescale 1ns / 1ps
module eight_bit_alu_with_bit_ops_tb;
	import alu8_pkg::*;

	// The clock runs at 8 ns. The watchdog gives up after this many cycles in which
	// no transaction moves on either channel while work is still outstanding. That is
	// far longer than the forced output hold plus any random stall run.
	localparam int unsigned HALF_PERIOD  = 4;
	localparam int unsigned STALL_LIMIT  = 1000;
	localparam int unsigned HOLD_CYCLES  = 64;
	localparam int unsigned TAIL_CYCLES  = 8;
	localparam int unsigned PHASE_ITEMS  = 440;
	localparam int unsigned FILL_ITEMS   = 90;

	// Codes 19..31 are not assigned to any operation. The block must pass the flags
	// through and must not write anything back.
	localparam logic [4:0] OP_UNUSED_LO = 5'd19;
	localparam logic [4:0] OP_UNUSED_HI = 5'd31;

	// Single-flag masks in the packed Z/N/H/C nibble.
	localparam logic [3:0] F_Z = 4'(1 << FLAG_Z);
	localparam logic [3:0] F_N = 4'(1 << FLAG_N);
	localparam logic [3:0] F_H = 4'(1 << FLAG_H);
	localparam logic [3:0] F_C = 4'(1 << FLAG_C);

	typedef struct packed {
		logic [4:0]  op;
		logic [15:0] a;
		logic [15:0] b;
		logic [3:0]  fl;
	} alu_request_t;

	typedef struct packed {
		logic [15:0] value;
		logic [3:0]  flags;
		logic        wr;
	} alu_outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [4:0]  req_type = '0;
	logic [15:0] operand_a = '0;
	logic [15:0] operand_b = '0;
	logic [3:0]  flags_in = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] result;
	logic [3:0]  flags_out;
	logic        result_write;

	// Operations that wait to be offered, and the outcomes of operations that the
	// block has taken but not yet returned, oldest first.
	alu_request_t op_backlog[$];
	alu_outcome_t expected_outcomes[$];

	// Idling percentages and the back-pressure trigger. Only the stimulus process
	// writes these, and it does so on the falling edge, so the clocked processes
	// always read settled values.
	int unsigned send_idle_pct = 0;
	int unsigned rx_stall_pct = 0;
	int unsigned hold_stamp = 0;

	int unsigned accepted_cnt = 0;
	int unsigned returned_cnt = 0;
	int unsigned error_cnt = 0;
	int unsigned idle_cycles = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	logic [31:0] ops_hit = '0;

	eight_bit_alu_with_bit_ops dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.operand_a    (operand_a),
		.operand_b    (operand_b),
		.flags_in     (flags_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result       (result),
		.flags_out    (flags_out),
		.result_write (result_write)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic logic [3:0] flag_nibble(logic z, logic n, logic h, logic c);
		logic [3:0] f;
		f = '0;
		f[FLAG_Z] = z;
		f[FLAG_N] = n;
		f[FLAG_H] = h;
		f[FLAG_C] = c;
		return f;
	endfunction

	// Computes what the ALU must return for one operation. Eight-bit operations look
	// only at the low bytes of the operands and return a value with a zero upper byte.
	function automatic alu_outcome_t compute_alu_outcome(alu_request_t rq);
		logic [7:0]  a, b, r8, adj;
		logic [15:0] v16;
		logic [8:0]  wide9;
		logic [4:0]  nib5;
		logic [12:0] wide13;
		logic [16:0] wide17;
		logic        cin, cy, cout, neg;
		alu_outcome_t o;
		a = rq.a[7:0];
		b = rq.b[7:0];
		cin = rq.fl[FLAG_C];
		neg = rq.fl[FLAG_N];
		r8 = 8'h00;
		v16 = 16'h0000;
		adj = 8'h00;
		cy = 1'b0;
		cout = 1'b0;
		o.flags = rq.fl;
		o.wr = 1'b1;
		case (rq.op)
			OP_ADD, OP_ADC: begin
				cy = (rq.op == OP_ADC) ? cin : 1'b0;
				wide9 = {1'b0, a} + {1'b0, b} + {8'h00, cy};
				nib5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cy};
				r8 = wide9[7:0];
				o.flags = flag_nibble(r8 == 8'h00, 1'b0, nib5[4], wide9[8]);
			end
			OP_SUB, OP_SBC, OP_CP: begin
				// A negative difference shows up as a set top bit: that is the borrow.
				cy = (rq.op == OP_SBC) ? cin : 1'b0;
				wide9 = {1'b0, a} - {1'b0, b} - {8'h00, cy};
				nib5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, cy};
				r8 = wide9[7:0];
				o.flags = flag_nibble(r8 == 8'h00, 1'b1, nib5[4], wide9[8]);
				if (rq.op == OP_CP) begin
					r8 = a;
					o.wr = 1'b0;
				end
			end
			OP_AND: begin
				r8 = a & b;
				o.flags = flag_nibble(r8 == 8'h00, 1'b0, 1'b1, 1'b0);
			end
			OP_XOR: begin
				r8 = a ^ b;
				o.flags = flag_nibble(r8 == 8'h00, 1'b0, 1'b0, 1'b0);
			end
			OP_OR: begin
				r8 = a | b;
				o.flags = flag_nibble(r8 == 8'h00, 1'b0, 1'b0, 1'b0);
			end
			OP_RLCA: begin
				r8 = {a[6:0], a[7]};
				o.flags = flag_nibble(1'b0, 1'b0, 1'b0, a[7]);
			end
			OP_RRCA: begin
				r8 = {a[0], a[7:1]};
				o.flags = flag_nibble(1'b0, 1'b0, 1'b0, a[0]);
			end
			OP_RLA: begin
				r8 = {a[6:0], cin};
				o.flags = flag_nibble(1'b0, 1'b0, 1'b0, a[7]);
			end
			OP_RRA: begin
				r8 = {cin, a[7:1]};
				o.flags = flag_nibble(1'b0, 1'b0, 1'b0, a[0]);
			end
			OP_DAA: begin
				if (rq.fl[FLAG_H] || (!neg && a[3:0] > DAA_LO_LIMIT))
					adj = {4'h0, DAA_FIX};
				if (cin || (!neg && a > DAA_LIMIT)) begin
					adj = adj | {DAA_FIX, 4'h0};
					cout = 1'b1;
				end
				r8 = neg ? (a - adj) : (a + adj);
				o.flags = flag_nibble(r8 == 8'h00, neg, 1'b0, cout);
			end
			OP_CPL: begin
				r8 = ~a;
				o.flags = flag_nibble(rq.fl[FLAG_Z], 1'b1, 1'b1, cin);
			end
			OP_SCF: begin
				r8 = a;
				o.wr = 1'b0;
				o.flags = flag_nibble(rq.fl[FLAG_Z], 1'b0, 1'b0, 1'b1);
			end
			OP_CCF: begin
				r8 = a;
				o.wr = 1'b0;
				o.flags = flag_nibble(rq.fl[FLAG_Z], 1'b0, 1'b0, ~cin);
			end
			OP_CB: begin
				case (b[7:6])
					CB_GRP_BIT: begin
						r8 = a;
						o.wr = 1'b0;
						o.flags = flag_nibble(~a[b[5:3]], 1'b0, 1'b1, cin);
					end
					CB_GRP_RES: r8 = a & ~(8'h01 << b[5:3]);
					CB_GRP_SET: r8 = a | (8'h01 << b[5:3]);
					default: begin
						case (b[5:3])
							CB_RLC: begin
								cout = a[7];
								r8 = {a[6:0], a[7]};
							end
							CB_RRC: begin
								cout = a[0];
								r8 = {a[0], a[7:1]};
							end
							CB_RL: begin
								cout = a[7];
								r8 = {a[6:0], cin};
							end
							CB_RR: begin
								cout = a[0];
								r8 = {cin, a[7:1]};
							end
							CB_SLA: begin
								cout = a[7];
								r8 = {a[6:0], 1'b0};
							end
							CB_SRA: begin
								cout = a[0];
								r8 = {a[7], a[7:1]};
							end
							CB_SWAP: r8 = {a[3:0], a[7:4]};
							default: begin
								cout = a[0];
								r8 = {1'b0, a[7:1]};
							end
						endcase
						o.flags = flag_nibble(r8 == 8'h00, 1'b0, 1'b0, cout);
					end
				endcase
			end
			OP_ADD16: begin
				wide17 = {1'b0, rq.a} + {1'b0, rq.b};
				wide13 = {1'b0, rq.a[11:0]} + {1'b0, rq.b[11:0]};
				v16 = wide17[15:0];
				o.flags = flag_nibble(rq.fl[FLAG_Z], 1'b0, wide13[12], wide17[16]);
			end
			OP_SP_E8: begin
				// The byte is signed for the sum, but the carries are unsigned ones
				// out of the low byte of SP.
				v16 = rq.a + {{8{b[7]}}, b};
				nib5 = {1'b0, rq.a[3:0]} + {1'b0, b[3:0]};
				wide9 = {1'b0, rq.a[7:0]} + {1'b0, b};
				o.flags = flag_nibble(1'b0, 1'b0, nib5[4], wide9[8]);
			end
			default: o.wr = 1'b0;
		endcase
		if (rq.op == OP_ADD16 || rq.op == OP_SP_E8)
			o.value = v16;
		else
			o.value = {8'h00, r8};
		return o;
	endfunction

	// Driver. It records the outcome of each transaction as it is accepted, then
	// either presents the next pending operation or idles. Valid is held with a
	// stable payload until the block takes it.
	always @(posedge clk or negedge arst_n) begin : drive_blk
		alu_request_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			req_type <= '0;
			operand_a <= '0;
			operand_b <= '0;
			flags_in <= '0;
		end else begin
			if (in_valid && in_ready) begin
				expected_outcomes.push_back(compute_alu_outcome(
					alu_request_t'{req_type, operand_a, operand_b, flags_in}));
				accepted_cnt <= accepted_cnt + 1;
				ops_hit[req_type] <= 1'b1;
			end
			if (!in_valid || in_ready) begin
				if (op_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = op_backlog.pop_front();
					in_valid <= 1'b1;
					req_type <= nxt.op;
					operand_a <= nxt.a;
					operand_b <= nxt.b;
					flags_in <= nxt.fl;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor. It checks every returned transaction against the oldest outcome and
	// drives out_ready. A change of hold_stamp starts a long hold, during which the
	// pipeline must fill and then push back on the input channel.
	always @(posedge clk or negedge arst_n) begin : monitor_blk
		alu_outcome_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			hold_seen <= 0;
		end else begin
			if (out_valid && out_ready) begin
				returned_cnt <= returned_cnt + 1;
				if (expected_outcomes.size() == 0) begin
					$display("%0t: result with no operation pending: value %h flags %b write %b",
						$time, result, flags_out, result_write);
					error_cnt <= error_cnt + 1;
				end else begin
					want = expected_outcomes.pop_front();
					if (result !== want.value || flags_out !== want.flags
							|| result_write !== want.wr)
						error_cnt <= error_cnt + 1;
					if (result !== want.value)
						$display("%0t: result mismatch: expected %h, actual %h",
							$time, want.value, result);
					if (flags_out !== want.flags)
						$display("%0t: flags_out mismatch: expected %b, actual %b",
							$time, want.flags, flags_out);
					if (result_write !== want.wr)
						$display("%0t: result_write mismatch: expected %b, actual %b",
							$time, want.wr, result_write);
				end
			end
			if (hold_seen != hold_stamp) begin
				hold_seen <= hold_stamp;
				hold_left <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// Watchdog. It counts cycles in which neither channel moves while something is
	// still outstanding.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((in_valid && in_ready) || (out_valid && out_ready)
				|| (!in_valid && op_backlog.size() == 0 && expected_outcomes.size() == 0)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles, %0d results outstanding",
				$time, idle_cycles, expected_outcomes.size());
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic push_op(logic [4:0] op, logic [15:0] a, logic [15:0] b, logic [3:0] fl);
		op_backlog.push_back(alu_request_t'{op, a, b, fl});
	endtask

	// Operand values lean toward the byte and nibble boundaries where carries,
	// borrows and zero results happen. The upper byte is left random in most cases
	// so that the eight-bit operations see garbage there too.
	function automatic logic [15:0] edgy_operand();
		logic [15:0] w;
		w = 16'($urandom);
		case ($urandom_range(9))
			0: w[7:0] = 8'h00;
			1: w[7:0] = 8'hFF;
			2: w[7:0] = 8'h80;
			3: w[3:0] = 4'hF;
			4: w[11:0] = 12'hFFF;
			5: w = 16'hFFFF;
			default: ;
		endcase
		return w;
	endfunction

	// Pushes a batch of random operations. Now and then an unassigned code is used.
	task automatic queue_random(int unsigned n);
		logic [4:0] op;
		repeat (n) begin
			if ($urandom_range(15) == 0)
				op = 5'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
			else
				op = 5'($urandom_range(OP_SP_E8));
			push_op(op, edgy_operand(), edgy_operand(), 4'($urandom));
		end
	endtask

	// Waits on the falling edge until every operation has been offered, taken and
	// answered.
	task automatic wait_drained();
		@(negedge clk);
		while (op_backlog.size() != 0 || in_valid || expected_outcomes.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_phase(int unsigned n, int unsigned idle_pct, int unsigned stall_pct);
		send_idle_pct = idle_pct;
		rx_stall_pct = stall_pct;
		queue_random(n);
		wait_drained();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed corner cases. They run with no idling on either side.
		push_op(OP_ADD, 16'h00FF, 16'h0001, 4'h0);              // zero, half and full carry
		push_op(OP_ADC, 16'hAB0F, 16'hCD00, F_C);               // carry-in makes half carry
		push_op(OP_SUB, 16'h123C, 16'h563C, 4'h0);              // equal operands
		push_op(OP_SBC, 16'h0000, 16'h0000, F_C);               // borrow through all bits
		push_op(OP_SBC, 16'h0010, 16'h000F, F_C);               // zero from an sbc
		push_op(OP_AND, 16'hFFF0, 16'hFF0F, 4'h0);
		push_op(OP_XOR, 16'h00FF, 16'hFFFF, 4'hF);
		push_op(OP_OR, 16'hFF00, 16'hFF00, 4'h0);               // upper bytes must be ignored
		push_op(OP_CP, 16'h0020, 16'h0021, 4'h0);               // compare never writes back
		push_op(OP_RLCA, 16'h0080, 16'h0000, F_Z);              // rotates clear Z
		push_op(OP_RRCA, 16'h0001, 16'h0000, 4'h0);
		push_op(OP_RLA, 16'h0080, 16'h0000, F_Z);
		push_op(OP_RRA, 16'h0001, 16'h0000, F_C);
		push_op(OP_DAA, 16'h009A, 16'h0000, 4'h0);              // both corrections after an add
		push_op(OP_DAA, 16'h0000, 16'h0000, F_N | F_H | F_C);   // both corrections after a sub
		push_op(OP_CPL, 16'h0055, 16'h0000, F_Z | F_C);
		push_op(OP_SCF, 16'h0042, 16'h0000, 4'hF);
		push_op(OP_CCF, 16'h0042, 16'h0000, F_C);
		push_op(OP_CB, 16'h0080, {8'hFF, CB_GRP_SHIFT, CB_RLC, 3'd5}, 4'h0);
		push_op(OP_CB, 16'h00F0, {8'h00, CB_GRP_SHIFT, CB_SWAP, 3'd0}, F_C);
		push_op(OP_CB, 16'h0081, {8'h00, CB_GRP_SHIFT, CB_SRA, 3'd7}, 4'h0);
		push_op(OP_CB, 16'h007F, {8'h00, CB_GRP_BIT, 3'd7, 3'd1}, F_N | F_C);
		push_op(OP_CB, 16'hFFFF, {8'h00, CB_GRP_RES, 3'd0, 3'd2}, 4'hF);
		push_op(OP_CB, 16'h0000, {8'h00, CB_GRP_SET, 3'd7, 3'd6}, 4'h0);
		push_op(OP_ADD16, 16'h0FFF, 16'h0001, 4'h0);            // half carry from bit 11
		push_op(OP_ADD16, 16'hFFFF, 16'h0001, F_Z);             // Z survives a 16-bit add
		push_op(OP_SP_E8, 16'hFFF8, 16'h00FF, F_Z | F_N);       // minus one, carries still set
		push_op(OP_SP_E8, 16'h000F, 16'h1280, 4'h0);            // most negative byte
		push_op(OP_UNUSED_HI, 16'hFFFF, 16'hFFFF, 4'hA);
		wait_drained();

		// Random phases: free flow, sparse input, heavy output stall, then both.
		run_phase(PHASE_ITEMS, 0, 0);
		run_phase(PHASE_ITEMS, 72, 0);
		run_phase(PHASE_ITEMS, 0, 72);
		run_phase(PHASE_ITEMS, 27, 27);

		// Back-pressure: the output is held off for a long stretch while the input
		// keeps offering, so the pipeline fills and in_ready has to drop.
		send_idle_pct = 0;
		rx_stall_pct = 0;
		hold_stamp = hold_stamp + 1;
		queue_random(FILL_ITEMS);
		wait_drained();

		// Let a few more cycles pass to catch a stray result after the last one.
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("Summary: %0d transactions in, %0d out, %0d of 32 operation codes seen,",
			accepted_cnt, returned_cnt, $countones(ops_hit));
		$display("  over free-flow, idle, stall, mixed and long back-pressure phases.");
		if (error_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: sim.f
sv/alu8_pkg.sv
sv/eight_bit_alu_with_bit_ops.sv
tb/sv/eight_bit_alu_with_bit_ops_tb.sv
